>>> rtl/ultrasonic_echo_ranger_top_macros.svh
// assertion macros for the echo ranger
// the enclosing module must have clk and rst_n
`ifndef ULTRASONIC_ECHO_RANGER_TOP_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define UER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UER_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UER_ASSERT(lbl, prop, msg)
`define UER_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/uer_pkg.sv
package uer_pkg;

  // field widths
  localparam int COUNT_WIDTH = 16;
  localparam int OP_W        = 2;
  localparam int US_W        = 16;
  localparam int CM_W        = 11;
  localparam int TEMP_W      = 7;
  localparam int KHZ_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // divider sizing: count*1000 needs 26 bits
  localparam int DIV_NUM_W   = 26;
  localparam int DIV_DEN_W   = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);

  // speed of sound in dm/s
  localparam int SPD_W       = 12;
  localparam int SPD_BASE    = 3313;
  localparam int SPD_SLOPE   = 6;
  localparam int SPD_DROP_SH = 4;   // drop of 15 = 16 - 1
  localparam int RECIP_100   = 5243;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int SPD_Q_W     = 6;

  // scale factors and limits
  localparam int US_SCALE    = 1000;
  localparam int CM_SCALE    = 100;
  localparam int US_MAX      = 65535;

  // reset values of the registers
  localparam int TEMP_RESET  = 22;
  localparam int KHZ_RESET   = 1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KHZ  = 2'd1;

  // opcodes
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_OVF   = 2'd2;

  // result status
  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_OVF  = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TRIG = 2'd1,
    MODE_MEAS = 2'd2,
    MODE_FIN  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_US    = 2'd1,
    ST_CM    = 2'd2
  } state_t;

  typedef struct packed {
    logic div_us_start;
    logic div_cm_start;
    logic emit_ok;
    logic emit_ovf;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/uer_if.sv
interface uer_in_if;
  import uer_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        opcode;
  logic [COUNT_WIDTH-1:0] echo_count;
  modport source (output valid, output opcode, output echo_count, input ready);
  modport sink (input valid, input opcode, input echo_count, output ready);
endinterface

interface uer_out_if;
  import uer_pkg::*;
  logic            valid;
  logic            ready;
  logic            status;
  logic [US_W-1:0] echo_us;
  logic [CM_W-1:0] distance_cm;
  modport source (output valid, output status, output echo_us, output distance_cm,
                  input ready);
  modport sink (input valid, input status, input echo_us, input distance_cm,
                output ready);
endinterface

interface uer_cfg_if;
  import uer_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/ultrasonic_echo_ranger_top.sv
// an overflow abort has its result valid in the cycle after its transfer
// a second capture edge has its result valid after two 26-step shift-subtract
// divisions run one after the other in the shared divider
// input ready holds low while a result waits; the next item can transfer
// with the result
// synchronous active-low reset: mode idle, temperature 22 C, counter 1000 kHz
module ultrasonic_echo_ranger_top (
  input  logic       clk,
  input  logic       rst_n,
  uer_in_if.sink     in_ch,
  uer_out_if.source  out_ch,
  uer_cfg_if.sink    cfg_ch
);
  import uer_pkg::*;

  cmd_t cmd;
  sts_t sts;

  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  uer_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_echo_count   (in_ch.echo_count),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .cfg_ready       (cfg_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_echo_us     (out_ch.echo_us),
    .out_distance_cm (out_ch.distance_cm)
  );

endmodule

>>> rtl/uer_div.sv
module uer_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [uer_pkg::DIV_NUM_W-1:0]  dividend,
  input  logic [uer_pkg::DIV_DEN_W-1:0]  divisor,
  output logic                           done,
  output logic [uer_pkg::DIV_NUM_W-1:0]  quotient
);
  import uer_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                   busy_r;
  logic                   done_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [DIV_NUM_W-1:0]   num_r;
  logic [DIV_DEN_W-1:0]   den_r;
  logic [DIV_DEN_W-1:0]   rem_r;
  logic [DIV_DEN_W:0]     trial;
  logic                   qbit;
  logic [DIV_DEN_W-1:0]   rem_nxt;

  // one restoring step: shift in next dividend bit, try subtract
  always_comb begin
    trial   = {rem_r, num_r[DIV_NUM_W-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

>>> rtl/uer_ctrl.sv
`include "ultrasonic_echo_ranger_top_macros.svh"

module uer_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [uer_pkg::OP_W-1:0] in_opcode,
  output logic                     in_ready,
  input  uer_pkg::sts_t            sts,
  output uer_pkg::cmd_t            cmd
);
  import uer_pkg::*;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_READY) && !sts.out_busy;
  assign accept   = in_valid && in_ready;

  // state and mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_READY;
      mode_r  <= MODE_IDLE;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // next state and echo mode
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    unique case (state_r)
      ST_READY: begin
        if (accept) begin
          priority if (in_opcode == OP_START) begin
            mode_nxt = MODE_TRIG;
          end else if (in_opcode == OP_EDGE) begin
            if (mode_r == MODE_TRIG) begin
              mode_nxt = MODE_MEAS;
            end else if (mode_r == MODE_MEAS) begin
              mode_nxt  = MODE_FIN;
              state_nxt = ST_US;
            end
          end else if (in_opcode == OP_OVF) begin
            if (mode_r == MODE_TRIG || mode_r == MODE_MEAS) begin
              mode_nxt = MODE_IDLE;
            end
          end else begin
            mode_nxt = mode_r;
          end
        end
      end
      ST_US: begin
        if (sts.div_done) begin
          state_nxt = ST_CM;
        end
      end
      ST_CM: begin
        if (sts.div_done) begin
          state_nxt = ST_READY;
        end
      end
      default: begin
        state_nxt = ST_READY;
      end
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd.div_us_start = accept && (in_opcode == OP_EDGE) && (mode_r == MODE_MEAS);
    cmd.div_cm_start = (state_r == ST_US) && sts.div_done;
    cmd.emit_ok      = (state_r == ST_CM) && sts.div_done;
    cmd.emit_ovf     = accept && (in_opcode == OP_OVF) &&
                       (mode_r == MODE_TRIG || mode_r == MODE_MEAS);
  end

  `UER_ASSERT(a_done_while_dividing, sts.div_done |-> (state_r == ST_US || state_r == ST_CM), "divider done outside a division")
  `UER_ASSERT(a_ok_returns_ready, cmd.emit_ok |=> (state_r == ST_READY), "no return to ready after result")
  `UER_ASSERT(a_div_means_finished, (state_r != ST_READY) |-> (mode_r == MODE_FIN), "division running while not finished")
  `UER_ASSERT(a_ovf_goes_idle, cmd.emit_ovf |=> (mode_r == MODE_IDLE), "overflow did not return to idle")

endmodule

>>> rtl/uer_dp.sv
module uer_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  uer_pkg::cmd_t                   cmd,
  output uer_pkg::sts_t                   sts,
  input  logic [uer_pkg::COUNT_WIDTH-1:0] in_echo_count,
  input  logic                            cfg_valid,
  input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            cfg_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_status,
  output logic [uer_pkg::US_W-1:0]        out_echo_us,
  output logic [uer_pkg::CM_W-1:0]        out_distance_cm
);
  import uer_pkg::*;

  logic [TEMP_W-1:0]            temp_r;
  logic [KHZ_W-1:0]             khz_r;
  logic [SPD_W-1:0]             a0_r;
  logic [SPD_W-1:0]             a1_r;
  logic [SPD_Q_W-1:0]           q_r;
  logic [SPD_W-1:0]             spd_r;
  logic [SPD_W+RECIP_W-1:0]     recip_prod;
  logic                         div_start;
  logic [DIV_NUM_W-1:0]         div_num;
  logic [DIV_DEN_W-1:0]         div_den;
  logic                         div_done;
  logic [DIV_NUM_W-1:0]         div_quot;
  logic [US_W-1:0]              us_sat;
  logic                         out_valid_r;
  logic                         status_r;
  logic [US_W-1:0]              us_r;
  logic [CM_W-1:0]              cm_r;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= TEMP_W'(TEMP_RESET);
      khz_r  <= KHZ_W'(KHZ_RESET);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TEMP) begin
        temp_r <= cfg_data[TEMP_W-1:0];
      end else if (cfg_index == CFG_KHZ) begin
        khz_r <= cfg_data[KHZ_W-1:0];
      end
    end
  end

  // airspeed pipeline: a = base + 6t, then a - (a/100)*15; stages a0, a1/q, spd
  assign recip_prod = (SPD_W+RECIP_W)'(a0_r) * (SPD_W+RECIP_W)'(RECIP_100);
  always_ff @(posedge clk) begin
    a0_r  <= SPD_W'(SPD_BASE) + SPD_W'(temp_r) * SPD_W'(SPD_SLOPE);
    a1_r  <= a0_r;
    q_r   <= recip_prod[RECIP_SHIFT+SPD_Q_W-1:RECIP_SHIFT];
    spd_r <= a1_r - ((SPD_W'(q_r) << SPD_DROP_SH) - SPD_W'(q_r));
  end

  // saturate the first quotient to microseconds
  assign us_sat = (div_quot > DIV_NUM_W'(US_MAX)) ? US_W'(US_MAX) : div_quot[US_W-1:0];

  // divider operand select
  always_comb begin
    div_start = cmd.div_us_start || cmd.div_cm_start;
    if (cmd.div_us_start) begin
      div_num = DIV_NUM_W'(in_echo_count) * DIV_NUM_W'(US_SCALE);
      div_den = khz_r;
    end else begin
      div_num = DIV_NUM_W'(us_sat) * DIV_NUM_W'(CM_SCALE);
      div_den = DIV_DEN_W'(spd_r);
    end
  end

  uer_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quot)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ok || cmd.emit_ovf) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ovf) begin
      status_r <= STAT_OVF;
      us_r     <= '0;
      cm_r     <= '0;
    end else begin
      if (cmd.div_cm_start) begin
        us_r <= us_sat;
      end
      if (cmd.emit_ok) begin
        status_r <= STAT_DONE;
        cm_r     <= div_quot[CM_W:1];
      end
    end
  end

  assign sts.div_done    = div_done;
  assign sts.out_busy    = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_echo_us     = us_r;
  assign out_distance_cm = cm_r;

endmodule
